/* rtl/core/skf_pkg.sv */
// Shared types, widths and helpers for the scalar Kalman filter.
`default_nettype none

package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned WideW    = 36;

  localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEASURE_NOISE = 2'd1;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PSUM = 9'b000000010,
    S_DEN  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_MULV = 9'b000010000,
    S_UPDV = 9'b000100000,
    S_MULE = 9'b001000000,
    S_UPDE = 9'b010000000,
    S_CHG  = 9'b100000000
  } state_e;

  // clamp a wide signed value to the signed data range
  function automatic logic signed [DataW-1:0] sat_s(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'({1'b0, {(DataW-1){1'b1}}});
    lo = -hi - WideW'(1);
    if (v > hi) begin
      sat_s = hi[DataW-1:0];
    end else if (v < lo) begin
      sat_s = lo[DataW-1:0];
    end else begin
      sat_s = v[DataW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/scalar_kalman_filter.sv */
// Scalar Kalman filter: sequencer around one shared divider step and multiplier.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+----------------------------------
//  input    | in_valid_i / in_stall_o       | measured_speed_i
//  output   | out_valid_o / out_stall_i     | estimate_o, estimate_change_o
//  config   | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// The result beat becomes valid once the steps PSUM, DEN, DIV, MULV, UPDV, MULE, UPDE
// and CHG have run; the input stalls until the sequencer is back in idle. DIV runs the
// restoring divider, one gain bit per cycle. No new sample is taken before that.
// Both multiplications share one registered multiplier.
// Reset loads estimate 10.0, variance 2.0 and the noise registers' defaults.
// A held result beat waits in the output register; the next sample may be taken
// meanwhile, and its result waits in the last step until the register frees up.
`default_nettype none

module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned GAIN_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [DataW-1:0]   measured_speed_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [DataW-1:0]        estimate_o,
  output logic signed [DataW-1:0]        estimate_change_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [DataW-1:0]          cfg_data_i
);

  localparam int unsigned GainW = GAIN_BITS + 1;
  localparam int unsigned CntW  = $clog2(GAIN_BITS + 2);
  localparam int unsigned MulAW = 35;
  localparam int unsigned ProdW = MulAW + GainW + 1;
  localparam int unsigned RemW  = DataW + 2;

  localparam longint unsigned One      = 64'd1 << FRAC_BITS;
  localparam longint unsigned EstRaw   = 64'd10 * One;
  localparam longint unsigned SMax     = (64'd1 << (DataW - 1)) - 64'd1;
  localparam longint unsigned UMax     = (64'd1 << DataW) - 64'd1;
  localparam longint unsigned VarRaw   = 64'd2 * One;
  localparam logic [DataW-1:0] EstRst  = DataW'((EstRaw > SMax) ? SMax : EstRaw);
  localparam logic [DataW-1:0] VarRst  = DataW'((VarRaw > UMax) ? UMax : VarRaw);
  localparam logic [DataW-1:0] PnRst   = DataW'((One + 64'd500) / 64'd1000);
  localparam logic [DataW-1:0] MnRst   = DataW'(One >> 1);

  state_e                     state_q, state_d;
  logic [DataW-1:0]           pn_q, mn_q;
  logic [DataW-1:0]           var_q;
  logic signed [DataW-1:0]    est_q, old_q, meas_q;
  logic [DataW-1:0]           p_q;
  logic signed [DataW:0]      diff_q;
  logic [DataW:0]             den_q;
  logic [RemW-1:0]            rem_q;
  logic [GainW-1:0]           gain_q;
  logic [CntW-1:0]            cnt_q;
  logic signed [ProdW-1:0]    prod_q;
  logic                       out_valid_q;
  logic signed [DataW-1:0]    out_est_q, out_chg_q;

  logic                       in_acc, out_acc, out_free;
  logic [DataW:0]             psum;
  logic [RemW-1:0]            trial, den_ext;
  logic                       ge;
  logic signed [MulAW-1:0]    mul_a;
  logic signed [ProdW-1:0]    prod_sh;
  logic signed [WideW-1:0]    est_sum, chg_sum;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o       = out_valid_q;
  assign estimate_o        = out_est_q;
  assign estimate_change_o = out_chg_q;

  assign psum    = {1'b0, var_q} + {1'b0, pn_q};
  assign den_ext = {1'b0, den_q};
  assign trial   = (cnt_q == '0) ? rem_q : {rem_q[RemW-2:0], 1'b0};
  assign ge      = (den_q != '0) && (trial >= den_ext);

  assign mul_a   = (state_q == S_MULV) ? $signed({3'b000, p_q})
                                       : $signed({{2{diff_q[DataW]}}, diff_q});
  assign prod_sh = prod_q >>> GAIN_BITS;
  assign est_sum = {{(WideW-DataW){est_q[DataW-1]}}, est_q}
                 + {{(WideW-MulAW){prod_sh[MulAW-1]}}, prod_sh[MulAW-1:0]};
  assign chg_sum = {{(WideW-DataW){est_q[DataW-1]}}, est_q}
                 - {{(WideW-DataW){old_q[DataW-1]}}, old_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_PSUM;
      S_PSUM: state_d = S_DEN;
      S_DEN:  state_d = S_DIV;
      S_DIV:  if (cnt_q == CntW'(GAIN_BITS)) state_d = S_MULV;
      S_MULV: state_d = S_UPDV;
      S_UPDV: state_d = S_MULE;
      S_MULE: state_d = S_UPDE;
      S_UPDE: state_d = S_CHG;
      S_CHG:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pn_q        <= PnRst;
      mn_q        <= MnRst;
      var_q       <= VarRst;
      est_q       <= EstRst;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_PROCESS_NOISE) pn_q <= cfg_data_i;
        if (cfg_index_i == REG_MEASURE_NOISE) mn_q <= cfg_data_i;
      end
      if (state_q == S_DEN) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == S_UPDV) begin
        var_q <= p_q - prod_q[GAIN_BITS +: DataW];
      end
      if (state_q == S_UPDE) begin
        est_q <= sat_s(est_sum);
      end
      if (state_q == S_CHG && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= measured_speed_i;
      old_q  <= est_q;
    end
    case (state_q)
      S_PSUM: begin
        p_q    <= psum[DataW] ? {DataW{1'b1}} : psum[DataW-1:0];
        diff_q <= {meas_q[DataW-1], meas_q} - {est_q[DataW-1], est_q};
      end
      S_DEN: begin
        den_q  <= {1'b0, p_q} + {1'b0, mn_q};
        rem_q  <= {2'b00, p_q};
        gain_q <= '0;
      end
      S_DIV: begin
        rem_q  <= ge ? (trial - den_ext) : trial;
        gain_q <= {gain_q[GainW-2:0], ge};
      end
      S_MULV, S_MULE: begin
        prod_q <= mul_a * $signed({1'b0, gain_q});
      end
      S_CHG: begin
        if (out_free) begin
          out_est_q <= est_q;
          out_chg_q <= sat_s(chg_sum);
        end
      end
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_PSUM)
    else $error("accepted sample did not start the sequence");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q <= CntW'(GAIN_BITS))
    else $error("divider ran past its last step");

  a_gain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MULV |-> gain_q <= (GainW'(1) << GAIN_BITS))
    else $error("gain above unity");

  a_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPDV |=> var_q <= $past(p_q))
    else $error("variance grew on update");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHG && !out_free) |=> state_q == S_CHG)
    else $error("result dropped while output busy");

endmodule

`default_nettype wire
